@@ hdl/nkst_pkg.sv @@
`default_nettype none

package nkst_pkg;

    localparam int SLOTS      = 128;
    localparam int NAME_BYTES = 32;
    localparam int WORDS      = 4;
    localparam int WORD_W     = 64;
    localparam int KEY_W      = WORDS * WORD_W;
    localparam int KEY_BYTES  = KEY_W / 8;
    localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W      = $clog2(SLOTS + 1);

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_ADD    = 2'd1,
        OP_REMOVE = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_MISS = 2'd1,
        STAT_FULL = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [63:0] name_word0;
        logic [63:0] name_word1;
        logic [63:0] name_word2;
        logic [63:0] name_word3;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [6:0] slot;
        logic [7:0] used_count;
    } rsp_t;

    typedef struct packed {
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        logic [KEY_W-1:0]  wr_data;
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
    } store_ctl_t;

endpackage

`default_nettype wire

@@ hdl/nkst_norm.sv @@
`default_nettype none

module nkst_norm (
    input  nkst_pkg::req_t              req,
    output logic [nkst_pkg::KEY_W-1:0]  key
);
    import nkst_pkg::*;

    logic [KEY_W-1:0] raw;
    logic [KEY_BYTES-1:0] alive;

    assign raw = {req.name_word3, req.name_word2, req.name_word1, req.name_word0};

    // a byte survives only while every byte up to it is nonzero
    always_comb
    begin
        for (int b = 0; b < KEY_BYTES; b++)
        begin
            if (b == 0)
            begin
                alive[b] = (raw[8*b +: 8] != 8'd0) && (b < NAME_BYTES);
            end
            else
            begin
                alive[b] = alive[b-1] && (raw[8*b +: 8] != 8'd0) && (b < NAME_BYTES);
            end
            key[8*b +: 8] = alive[b] ? raw[8*b +: 8] : 8'd0;
        end
    end

endmodule

`default_nettype wire

@@ hdl/nkst_store.sv @@
`default_nettype none

module nkst_store (
    input  logic                         clk,
    input  nkst_pkg::store_ctl_t         ctl,
    output logic [nkst_pkg::KEY_W-1:0]   rd_data
);
    import nkst_pkg::*;

    logic [KEY_W-1:0] mem [SLOTS];

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[ctl.wr_addr] <= ctl.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data <= mem[ctl.rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ hdl/name_keyed_slot_table.sv @@
// channel | beat  | handshake              | fields
// --------+-------+------------------------+------------------------------------
// req     | in    | req_valid / req_stall  | opcode, name_word0..name_word3
// rsp     | out   | rsp_valid / rsp_stall  | status, slot, used_count
//
// a request steps through scan (every slot), drain and finish; the next request is accepted back in idle
// a single name comparator walks every slot through one store read port, one slot a cycle
// rst_n clears the valid bits, the used count and the sequencer; the name store is not cleared
// req_stall is high while a request is in flight; the result waits in the output register
// a stalled result holds the sequencer in its last step until the output register frees
`default_nettype none

module name_keyed_slot_table (
    input  logic               clk,
    input  logic               rst_n,
    input  nkst_pkg::req_t     req,
    input  logic               req_valid,
    output logic               req_stall,
    output nkst_pkg::rsp_t     rsp,
    output logic               rsp_valid,
    input  logic               rsp_stall
);
    import nkst_pkg::*;

    state_t state_reg, state_next;

    logic [KEY_W-1:0]  key_norm;
    logic [KEY_W-1:0]  key_reg;
    logic [1:0]        op_reg;
    logic [KEY_W-1:0]  rd_data;
    store_ctl_t        ctl;

    logic [SLOT_W-1:0] rd_idx_reg, rd_idx_next;
    logic              cmp_valid_reg, cmp_valid_next;
    logic [SLOT_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic              hit_found_reg, hit_found_next;
    logic [SLOT_W-1:0] hit_slot_reg, hit_slot_next;
    logic              free_found_reg, free_found_next;
    logic [SLOT_W-1:0] free_slot_reg, free_slot_next;
    logic [SLOTS-1:0]  valid_reg, valid_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              out_valid_reg, out_valid_next;
    rsp_t              out_reg, out_next;

    logic              accept;
    logic              load;
    logic              match;
    logic              add_ok;
    logic              rem_ok;

    nkst_norm u_norm (
        .req (req),
        .key (key_norm)
    );

    nkst_store u_store (
        .clk     (clk),
        .ctl     (ctl),
        .rd_data (rd_data)
    );

    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;
    assign load      = (state_reg == S_FINISH) && (!out_valid_reg || !rsp_stall);
    assign match     = cmp_valid_reg && valid_reg[cmp_idx_reg] && (rd_data == key_reg);
    assign add_ok    = (op_reg == OP_ADD) && !hit_found_reg && free_found_reg;
    assign rem_ok    = (op_reg == OP_REMOVE) && hit_found_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg <= key_norm;
            op_reg  <= req.opcode;
        end
        out_reg       <= out_next;
        cmp_idx_reg   <= cmp_idx_next;
        hit_slot_reg  <= hit_slot_next;
        free_slot_reg <= free_slot_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            rd_idx_reg     <= '0;
            cmp_valid_reg  <= 1'b0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            valid_reg      <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rd_idx_reg     <= rd_idx_next;
            cmp_valid_reg  <= cmp_valid_next;
            hit_found_reg  <= hit_found_next;
            free_found_reg <= free_found_next;
            valid_reg      <= valid_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        rd_idx_next     = rd_idx_reg;
        cmp_valid_next  = 1'b0;
        cmp_idx_next    = rd_idx_reg;
        hit_found_next  = hit_found_reg;
        hit_slot_next   = hit_slot_reg;
        free_found_next = free_found_reg;
        free_slot_next  = free_slot_reg;
        valid_next      = valid_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg && rsp_stall;
        out_next        = out_reg;
        ctl.wr_en       = 1'b0;
        ctl.wr_addr     = free_slot_reg;
        ctl.wr_data     = key_reg;
        ctl.rd_en       = 1'b0;
        ctl.rd_addr     = rd_idx_reg;

        // compare stage sees the row that the store read in the previous cycle
        if (match && !hit_found_reg)
        begin
            hit_found_next = 1'b1;
            hit_slot_next  = cmp_idx_reg;
        end
        if (cmp_valid_reg && !valid_reg[cmp_idx_reg] && !free_found_reg)
        begin
            free_found_next = 1'b1;
            free_slot_next  = cmp_idx_reg;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rd_idx_next     = '0;
                    hit_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    state_next      = S_SCAN;
                end
            end
            S_SCAN:
            begin
                ctl.rd_en      = 1'b1;
                cmp_valid_next = 1'b1;
                cmp_idx_next   = rd_idx_reg;
                if (rd_idx_reg == SLOT_W'(SLOTS - 1))
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    rd_idx_next = SLOT_W'(rd_idx_reg + 1'b1);
                end
            end
            S_DRAIN:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    out_next.status     = STAT_MISS;
                    out_next.slot       = '0;
                    out_next.used_count = 8'(count_reg);
                    priority if (add_ok)
                    begin
                        ctl.wr_en                 = 1'b1;
                        valid_next[free_slot_reg] = 1'b1;
                        count_next                = CNT_W'(count_reg + 1'b1);
                        out_next.status           = STAT_OK;
                        out_next.slot             = 7'(free_slot_reg);
                        out_next.used_count       = 8'(count_reg + 1'b1);
                    end
                    else if (rem_ok)
                    begin
                        valid_next[hit_slot_reg] = 1'b0;
                        count_next               = CNT_W'(count_reg - 1'b1);
                        out_next.status          = STAT_OK;
                        out_next.slot            = 7'(hit_slot_reg);
                        out_next.used_count      = 8'(count_reg - 1'b1);
                    end
                    else if ((op_reg == OP_LOOKUP) && hit_found_reg)
                    begin
                        out_next.status = STAT_OK;
                        out_next.slot   = 7'(hit_slot_reg);
                    end
                    else if ((op_reg == OP_ADD) && !hit_found_reg)
                    begin
                        out_next.status = STAT_FULL;
                    end
                    else
                    begin
                        out_next.status = STAT_MISS;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_count_tracks_valid: assert property (
        @(posedge clk) disable iff (!rst_n)
        count_reg == CNT_W'($countones(valid_reg)))
    else $error("used count differs from valid bits");

    a_cmp_in_scan: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmp_valid_reg |-> (state_reg == S_SCAN || state_reg == S_DRAIN))
    else $error("compare outside scan");

    a_add_sets_valid: assert property (
        @(posedge clk) disable iff (!rst_n)
        (load && add_ok) |=> valid_reg[$past(free_slot_reg)])
    else $error("claimed slot not marked valid");

    a_fail_slot_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.status != STAT_OK) |-> (out_reg.slot == '0))
    else $error("failed request reports a slot");

    a_hit_is_valid: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && hit_found_reg) |-> valid_reg[hit_slot_reg])
    else $error("hit on an empty slot");

endmodule

`default_nettype wire
